// ===== design/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpd_pkg: shared types and constants for the byte-level piece decoder
// utf-8 lead decode constants, reverse byte map and queue types
// ----------------------------------------------------------------------------
package bpd_pkg;

  // request queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // utf-8 lead byte classes
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Tag   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Tag   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Tag   = 8'hF0;
  localparam logic [7:0] Lead2Bits  = 8'h1F;
  localparam logic [7:0] Lead3Bits  = 8'h0F;
  localparam logic [7:0] Lead4Bits  = 8'h07;
  localparam logic [7:0] ContBits   = 8'h3F;

  // reverse byte map ranges
  localparam logic [20:0] PrintLo   = 21'h21;
  localparam logic [20:0] PrintHi   = 21'h7E;
  localparam logic [20:0] Latin1Lo  = 21'hA1;
  localparam logic [20:0] Latin1Hi  = 21'hAC;
  localparam logic [20:0] Latin2Lo  = 21'hAE;
  localparam logic [20:0] Latin2Hi  = 21'hFF;
  localparam logic [20:0] ShiftLo   = 21'h100;
  localparam logic [20:0] ShiftHi   = 21'h143;
  localparam logic [6:0]  CtrlCount = 7'd33;
  localparam logic [6:0]  HighCount = 7'd67;
  localparam logic [7:0]  HighBase  = 8'h5E;
  localparam logic [7:0]  SoftHyph  = 8'hAD;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } bpd_map_t;

  // one request: the results of one completed or cut-short sequence
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            mapped;
    logic            piece_last;
  } bpd_run_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } bpd_q_stat_t;

  function automatic bpd_map_t bpd_reverse_map(input logic [20:0] cp);
    bpd_map_t   r;
    logic [6:0] n;
    r.hit   = 1'b0;
    r.value = cp[7:0];
    n       = cp[6:0];
    if ((cp >= PrintLo && cp <= PrintHi) || (cp >= Latin1Lo && cp <= Latin1Hi) ||
        (cp >= Latin2Lo && cp <= Latin2Hi)) begin
      r.hit = 1'b1;
    end else if (cp >= ShiftLo && cp <= ShiftHi) begin
      r.hit = 1'b1;
      if (n < CtrlCount) begin
        r.value = {1'b0, n};
      end else if (n < HighCount) begin
        r.value = {1'b0, n} + HighBase;
      end else begin
        r.value = SoftHyph;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/bpd_in_if.sv =====
// ----------------------------------------------------------------------------
// bpd_in_if: input byte channel
// valid/ready handshake carrying one byte of a token piece
// ----------------------------------------------------------------------------
interface bpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       piece_last;

  modport source (output valid, output in_byte, output piece_last, input ready);
  modport sink   (input valid, input in_byte, input piece_last, output ready);
endinterface

// ===== design/bpd_out_if.sv =====
// ----------------------------------------------------------------------------
// bpd_out_if: output byte channel
// valid/ready handshake carrying one decoded byte
// ----------------------------------------------------------------------------
interface bpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       was_mapped;
  logic       run_last;
  logic       piece_done;

  modport source (output valid, output out_byte, output was_mapped, output run_last,
                  output piece_done, input ready);
  modport sink   (input valid, input out_byte, input was_mapped, input run_last,
                  input piece_done, output ready);
endinterface

// ===== design/bpd_front.sv =====
// ----------------------------------------------------------------------------
// bpd_front: utf-8 gather and reverse map lookup
// builds one request per completed or cut-short sequence
// ----------------------------------------------------------------------------
module bpd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bpd_in_if.sink               in_i,
  input  bpd_pkg::bpd_q_stat_t q_stat_i,
  output logic                 push_o,
  output bpd_pkg::bpd_run_t    run_o
);
  import bpd_pkg::*;

  logic [1:0]  rem_q, rem_d;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  hc_q, hc_d;
  logic [7:0]  held_q [3];

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  nxt_rem;
  logic [20:0] nxt_cp;
  logic [1:0]  nxt_hc;
  logic        done;
  bpd_map_t    map;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  always_comb begin
    nxt_hc = hc_q;
    if (rem_q == 2'd0) begin
      nxt_hc = 2'd0;
      if (b < AsciiLimit) begin
        nxt_cp  = {13'd0, b};
        nxt_rem = 2'd0;
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        nxt_cp  = {13'd0, b & Lead2Bits};
        nxt_rem = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        nxt_cp  = {13'd0, b & Lead3Bits};
        nxt_rem = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        nxt_cp  = {13'd0, b & Lead4Bits};
        nxt_rem = 2'd3;
      end else begin
        // stray continuation or invalid lead
        nxt_cp  = 21'd0;
        nxt_rem = 2'd0;
      end
    end else begin
      nxt_cp  = {cp_q[14:0], b[5:0] & ContBits[5:0]};
      nxt_rem = rem_q - 2'd1;
    end
  end

  assign done = (nxt_rem == 2'd0) || in_i.piece_last;
  assign map  = bpd_reverse_map(nxt_cp);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      run_o.bytes[i] = (2'(i) < nxt_hc) ? held_q[i] : b;
    end
    run_o.bytes[3]    = b;
    run_o.last_idx    = nxt_hc;
    run_o.mapped      = map.hit;
    run_o.piece_last  = in_i.piece_last;
    if (map.hit) begin
      run_o.bytes[0] = map.value;
      run_o.last_idx = 2'd0;
    end
  end

  assign push_o = accept && done;

  always_comb begin
    rem_d = rem_q;
    cp_d  = cp_q;
    hc_d  = hc_q;
    if (accept) begin
      if (done) begin
        rem_d = 2'd0;
        cp_d  = 21'd0;
        hc_d  = 2'd0;
      end else begin
        rem_d = nxt_rem;
        cp_d  = nxt_cp;
        hc_d  = nxt_hc + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      cp_q  <= 21'd0;
      hc_q  <= 2'd0;
    end else begin
      rem_q <= rem_d;
      cp_q  <= cp_d;
      hc_q  <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !done) begin
      held_q[nxt_hc] <= b;
    end
  end

endmodule

// ===== design/bpd_fifo.sv =====
// ----------------------------------------------------------------------------
// bpd_fifo: request queue
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module bpd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bpd_pkg::bpd_run_t    run_i,
  input  logic                 pop_i,
  output bpd_pkg::bpd_run_t    run_o,
  output bpd_pkg::bpd_q_stat_t q_stat_o
);
  import bpd_pkg::*;

  bpd_run_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign run_o          = mem_q[rd_q];
  assign q_stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign q_stat_o.count = cnt_q;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= run_i;
    end
  end

endmodule

// ===== design/bpd_back.sv =====
// ----------------------------------------------------------------------------
// bpd_back: result sequencer
// drains the head request, whenever the receiver is ready, one output byte per cycle
// ----------------------------------------------------------------------------
module bpd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpd_pkg::bpd_run_t    run_i,
  input  bpd_pkg::bpd_q_stat_t q_stat_i,
  output logic                 pop_o,
  bpd_out_if.source            out_o
);
  import bpd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       is_last;

  assign is_last          = (idx_q == run_i.last_idx);
  assign out_o.valid      = !q_stat_i.empty;
  assign out_o.out_byte   = run_i.bytes[idx_q];
  assign out_o.was_mapped = run_i.mapped;
  assign out_o.run_last   = is_last;
  assign out_o.piece_done = is_last && run_i.piece_last;

  assign fire  = out_o.valid && out_o.ready;
  assign pop_o = fire && is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== design/byte_level_bpe_piece_decoder.sv =====
// a result is written into the request queue and offered once it is at the queue head
// throughput: one input byte per cycle while the four-entry request queue has room
// output: one result byte per cycle while ready; a passthrough is sent byte by byte
// reset: asynchronous active low, clears sequence state, queue pointers and sequencer
// held bytes and queue payload are not reset
// ----------------------------------------------------------------------------
// byte_level_bpe_piece_decoder: byte-level bpe piece decoder
// gathers utf-8 sequences, maps codepoints back to raw bytes or passes them
// ----------------------------------------------------------------------------
module byte_level_bpe_piece_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpd_in_if.sink    in_i,
  bpd_out_if.source out_o
);
  import bpd_pkg::*;

  // front to queue
  logic        push;
  bpd_run_t    run_new;
  // queue to back
  logic        pop;
  bpd_run_t    run_head;
  bpd_q_stat_t q_stat;

  // front: lead decode, codepoint gather, reverse lookup
  bpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .run_o    (run_new)
  );

  // queue of pending requests, decouples input from output stalls
  bpd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .run_i    (run_new),
    .pop_i    (pop),
    .run_o    (run_head),
    .q_stat_o (q_stat)
  );

  // back: walks the head request one byte at a time
  bpd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .run_i    (run_head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  // queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCntW'(QDepth))
    else $error("request queue overflow");

  // occupancy follows push and pop
  a_q_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 3'd1))
    else $error("queue count missed a push");

  a_q_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (q_stat.count == $past(q_stat.count) - 3'd1))
    else $error("queue count missed a pop");

  // end of piece only on the final byte of a request
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.piece_done) |-> out_o.run_last)
    else $error("piece end without request end");
`endif

endmodule

// ===== bench/tb_byte_level_bpe_piece_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_level_bpe_piece_decoder: self-checking bench for the piece decoder
// feeds utf-8 token pieces byte by byte, predicts every decoded output byte
// and compares each accepted output byte against the oldest expected one
// ----------------------------------------------------------------------------
module tb_byte_level_bpe_piece_decoder;
  import bpd_pkg::*;

  // one decoded output byte as the block should offer it
  typedef struct packed {
    bit [7:0] value;
    bit       mapped;
    bit       run_end;
    bit       piece_end;
  } decoded_byte_t;

  // predicts the decoded bytes of every accepted input byte and checks them
  class piece_scoreboard;
    // own copy of the sequence state
    bit [1:0]        conts_left;
    bit [2:0]        seq_len;
    bit [20:0]       cp_acc;
    bit [7:0]        held[3];
    bit [1:0]        held_cnt;
    decoded_byte_t   expected_bytes[$];
    int unsigned     mismatches;

    function new();
      conts_left = '0;
      seq_len    = '0;
      cp_acc     = '0;
      held_cnt   = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // queue one expected output byte at the tail
    function void expect_result(input decoded_byte_t d);
      expected_bytes = {expected_bytes, d};
    endfunction

    // reverse byte map: printable codepoints give themselves, the shifted
    // range gives the unprintable bytes in ascending order
    function bit lookup_byte(input bit [20:0] cp, output bit [7:0] raw);
      int unsigned n;
      raw = cp[7:0];
      if ((cp >= PrintLo && cp <= PrintHi) || (cp >= Latin1Lo && cp <= Latin1Hi) ||
          (cp >= Latin2Lo && cp <= Latin2Hi)) begin
        return 1'b1;
      end
      if (cp >= ShiftLo && cp <= ShiftHi) begin
        n = int'(cp) - int'(ShiftLo);
        if (n < 33) begin
          raw = 8'(n);
        end else if (n < 67) begin
          raw = 8'(8'h7F + (n - 33));
        end else begin
          raw = SoftHyph;
        end
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void predict_byte_results(input bit [7:0] b, input bit last);
      bit [7:0]    run_bytes[4];
      int unsigned n;
      bit          hit;
      bit [7:0]    raw;
      decoded_byte_t d;
      n = 0;
      if (conts_left == 0) begin
        // lead byte picks the sequence length
        seq_len = 3'd1;
        cp_acc  = '0;
        if (b < AsciiLimit) begin
          cp_acc = 21'(b);
        end else if ((b & Lead2Mask) == Lead2Tag) begin
          cp_acc  = 21'(b & Lead2Bits);
          seq_len = 3'd2;
        end else if ((b & Lead3Mask) == Lead3Tag) begin
          cp_acc  = 21'(b & Lead3Bits);
          seq_len = 3'd3;
        end else if ((b & Lead4Mask) == Lead4Tag) begin
          cp_acc  = 21'(b & Lead4Bits);
          seq_len = 3'd4;
        end
        conts_left = 2'(seq_len - 3'd1);
        held_cnt   = '0;
      end else begin
        // continuation: low six bits appended, high bits ignored
        cp_acc     = {cp_acc[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
      end
      for (int i = 0; i < held_cnt; i++) begin
        run_bytes[n] = held[i];
        n++;
      end
      run_bytes[n] = b;
      n++;
      if (conts_left != 0 && !last) begin
        if (held_cnt < 3) begin
          held[held_cnt] = b;
          held_cnt++;
        end
        return;
      end
      hit = lookup_byte(cp_acc, raw);
      if (hit) begin
        d = '{value: raw, mapped: 1'b1, run_end: 1'b1, piece_end: last};
        expect_result(d);
      end else begin
        for (int i = 0; i < n; i++) begin
          d = '{value: run_bytes[i], mapped: 1'b0, run_end: (i == n - 1),
                piece_end: (i == n - 1) && last};
          expect_result(d);
        end
      end
      conts_left = '0;
      seq_len    = '0;
      cp_acc     = '0;
      held_cnt   = '0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_decoded(input decoded_byte_t got);
      decoded_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", got.value));
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (got.value != exp_b.value)
        report_mismatch($sformatf("out_byte %02h, want %02h", got.value, exp_b.value));
      if (got.mapped != exp_b.mapped)
        report_mismatch($sformatf("was_mapped %0b, want %0b", got.mapped, exp_b.mapped));
      if (got.run_end != exp_b.run_end)
        report_mismatch($sformatf("run_last %0b, want %0b", got.run_end, exp_b.run_end));
      if (got.piece_end != exp_b.piece_end)
        report_mismatch($sformatf("piece_done %0b, want %0b", got.piece_end,
                                  exp_b.piece_end));
    endtask

    task flush_leftover();
      while (expected_bytes.size() != 0) begin
        report_mismatch($sformatf("output byte %02h never came",
                                  expected_bytes[0].value));
        void'(expected_bytes.pop_front());
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bpd_in_if  in_if ();
  bpd_out_if out_if ();

  byte_level_bpe_piece_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  piece_scoreboard sb;
  int unsigned     sent_count;
  bit              long_hold_req;
  bit [7:0]        piece_q[$];

  // directed requests: {piece_last, in_byte}
  bit [8:0] directed_seq [25] = '{
    9'h1_41,                              // ascii hit ending a piece
    9'h0_00, 9'h0_7F,                     // unprintable ascii passes through
    9'h0_21, 9'h1_7E,                     // printable range edges
    9'h0_C4, 9'h0_80,                     // first shifted codepoint
    9'h0_C5, 9'h0_03,                     // last shifted codepoint, bad cont high bits
    9'h0_C2, 9'h0_A1,                     // latin range start
    9'h0_C2, 9'h0_AD,                     // soft hyphen codepoint is a miss
    9'h0_C0, 9'h0_A1,                     // overlong form of a printable
    9'h0_F0, 9'h0_9F, 9'h0_98, 9'h1_80,   // four byte miss ends the piece
    9'h0_80,                              // stray continuation as lead
    9'h1_FF,                              // invalid lead ending a piece
    9'h0_E2, 9'h1_82,                     // cut short, partial codepoint misses
    9'h0_E0, 9'h1_A1                      // cut short, partial codepoint hits
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_byte(input bit [7:0] b, input bit last);
    @(negedge clk_i);
    in_if.valid      = 1'b1;
    in_if.in_byte    = b;
    in_if.piece_last = last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.predict_byte_results(b, last);
    sent_count++;
  endtask

  task automatic idle_in(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_if.valid      = 1'b0;
      in_if.in_byte    = 8'($urandom_range(0, 255));
      in_if.piece_last = 1'($urandom_range(0, 1));
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // add one byte at the end of the piece being built
  task automatic queue_byte(input bit [7:0] v);
    piece_q = {piece_q, v};
  endtask

  task automatic push_cont(input bit broken);
    if (broken) queue_byte(8'($urandom_range(0, 255)));
    else queue_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // build one piece of mostly well-formed utf-8 with random content,
  // some noise, broken continuations and pieces cut mid-sequence
  task automatic make_piece();
    int unsigned ncp;
    int unsigned k;
    int unsigned last_len;
    int unsigned cut;
    piece_q.delete();
    ncp      = $urandom_range(1, 4);
    last_len = 1;
    repeat (ncp) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        queue_byte(8'($urandom_range(0, 127)));
        last_len = 1;
      end else if (k < 55) begin
        // lean on the shifted range, which maps back to unprintable bytes
        if ($urandom_range(0, 1)) queue_byte(8'hC4 + 8'($urandom_range(0, 1)));
        else queue_byte(8'hC0 | 8'($urandom_range(0, 31)));
        push_cont(1'b0);
        last_len = 2;
      end else if (k < 72) begin
        queue_byte(8'hE0 | 8'($urandom_range(0, 15)));
        push_cont(1'b0);
        push_cont(1'b0);
        last_len = 3;
      end else if (k < 85) begin
        queue_byte(8'hF0 | 8'($urandom_range(0, 7)));
        push_cont(1'b0);
        push_cont(1'b0);
        push_cont(1'b0);
        last_len = 4;
      end else if (k < 93) begin
        queue_byte(8'($urandom_range(0, 255)));
        last_len = 1;
      end else begin
        queue_byte(8'hC0 | 8'($urandom_range(0, 63)));
        push_cont(1'b1);
        last_len = 2;
      end
    end
    if (last_len > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, last_len - 1);
      repeat (cut) void'(piece_q.pop_back());
    end
  endtask

  task automatic send_piece(input bit no_gaps);
    foreach (piece_q[i]) begin
      send_byte(piece_q[i], i == piece_q.size() - 1);
      if (!no_gaps) idle_in(gap_len());
    end
  endtask

  // output side: random back-pressure, with a long hold on request
  initial begin : drain_side
    int unsigned hold_left;
    int unsigned run_left;
    decoded_byte_t got;
    hold_left = 0;
    run_left  = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 80;
        run_left      = 0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        out_if.ready = 1'b1;
        run_left--;
      end else begin
        hold_left = gap_len();
        // now and then a long stretch with no back-pressure
        run_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
                                                  $urandom_range(1, 20);
        out_if.ready = (hold_left == 0);
        if (hold_left > 0) hold_left--;
      end
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got = '{value: out_if.out_byte, mapped: out_if.was_mapped,
                run_end: out_if.run_last, piece_end: out_if.piece_done};
        sb.check_decoded(got);
      end
    end
  end

  initial begin : feed_side
    bit pressure_done;
    bit drain_done;
    bit no_gaps;
    int unsigned n;
    sb               = new();
    sent_count       = 0;
    long_hold_req    = 1'b0;
    pressure_done    = 1'b0;
    drain_done       = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.piece_last = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corner cases
    foreach (directed_seq[i]) begin
      send_byte(directed_seq[i][7:0], directed_seq[i][8]);
      idle_in(gap_len());
    end
    idle_in(1);
    wait_drained();

    // random pieces
    while (sent_count < 330) begin
      if (!pressure_done && sent_count >= 110) begin
        // receiver holds off while requests keep coming, so the queue fills
        pressure_done = 1'b1;
        long_hold_req = 1'b1;
        n = 0;
        while (n < 24) begin
          make_piece();
          send_piece(1'b1);
          n += piece_q.size();
        end
      end
      if (!drain_done && sent_count >= 220) begin
        // sender stops until every output byte is out
        drain_done = 1'b1;
        idle_in(1);
        wait_drained();
      end
      make_piece();
      no_gaps = ($urandom_range(0, 4) == 0);
      send_piece(no_gaps);
    end
    idle_in(1);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.flush_leftover();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpd_pkg.sv
design/bpd_in_if.sv
design/bpd_out_if.sv
design/bpd_front.sv
design/bpd_fifo.sv
design/bpd_back.sv
design/byte_level_bpe_piece_decoder.sv
bench/tb_byte_level_bpe_piece_decoder.sv
